### sv/sqa_pkg.sv
package sqa_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int OPQ_DEPTH_DEF   = 4;

  // field widths
  localparam int CHAR_W = 7;
  localparam int SCAN_W = 8;

  // scancode bit 7 marks a release
  localparam int REL_BIT_POS = 7;

  // key codes with special meaning
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;

  // work passed from the classifier to the queue engine
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_READ = 2'd1,
    OP_PUSH = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CHAR_W-1:0] ch;
  } op_t;

  // us-qwerty set 1 lookup, pair is {plain, shifted}
  function automatic logic [CHAR_W-1:0] key_char(input logic [6:0] code,
                                                 input logic upper);
    logic [2*CHAR_W-1:0] pair;
    unique case (code)
      7'h01: pair = {7'h1B, 7'h1B};
      7'h02: pair = {7'h31, 7'h21};
      7'h03: pair = {7'h32, 7'h40};
      7'h04: pair = {7'h33, 7'h23};
      7'h05: pair = {7'h34, 7'h24};
      7'h06: pair = {7'h35, 7'h25};
      7'h07: pair = {7'h36, 7'h5E};
      7'h08: pair = {7'h37, 7'h26};
      7'h09: pair = {7'h38, 7'h2A};
      7'h0A: pair = {7'h39, 7'h28};
      7'h0B: pair = {7'h30, 7'h29};
      7'h0C: pair = {7'h2D, 7'h5F};
      7'h0D: pair = {7'h3D, 7'h2B};
      7'h0E: pair = {7'h08, 7'h08};
      7'h0F: pair = {7'h09, 7'h09};
      7'h10: pair = {7'h71, 7'h51};
      7'h11: pair = {7'h77, 7'h57};
      7'h12: pair = {7'h65, 7'h45};
      7'h13: pair = {7'h72, 7'h52};
      7'h14: pair = {7'h74, 7'h54};
      7'h15: pair = {7'h79, 7'h59};
      7'h16: pair = {7'h75, 7'h55};
      7'h17: pair = {7'h69, 7'h49};
      7'h18: pair = {7'h6F, 7'h4F};
      7'h19: pair = {7'h70, 7'h50};
      7'h1A: pair = {7'h5B, 7'h7B};
      7'h1B: pair = {7'h5D, 7'h7D};
      7'h1C: pair = {7'h0A, 7'h0A};
      7'h1E: pair = {7'h61, 7'h41};
      7'h1F: pair = {7'h73, 7'h53};
      7'h20: pair = {7'h64, 7'h44};
      7'h21: pair = {7'h66, 7'h46};
      7'h22: pair = {7'h67, 7'h47};
      7'h23: pair = {7'h68, 7'h48};
      7'h24: pair = {7'h6A, 7'h4A};
      7'h25: pair = {7'h6B, 7'h4B};
      7'h26: pair = {7'h6C, 7'h4C};
      7'h27: pair = {7'h3B, 7'h3A};
      7'h28: pair = {7'h27, 7'h22};
      7'h29: pair = {7'h60, 7'h7E};
      7'h2B: pair = {7'h5C, 7'h7C};
      7'h2C: pair = {7'h7A, 7'h5A};
      7'h2D: pair = {7'h78, 7'h58};
      7'h2E: pair = {7'h63, 7'h43};
      7'h2F: pair = {7'h76, 7'h56};
      7'h30: pair = {7'h62, 7'h42};
      7'h31: pair = {7'h6E, 7'h4E};
      7'h32: pair = {7'h6D, 7'h4D};
      7'h33: pair = {7'h2C, 7'h3C};
      7'h34: pair = {7'h2E, 7'h3E};
      7'h35: pair = {7'h2F, 7'h3F};
      7'h37: pair = {7'h2A, 7'h2A};
      7'h39: pair = {7'h20, 7'h20};
      default: pair = '0;
    endcase
    return upper ? pair[CHAR_W-1:0] : pair[2*CHAR_W-1:CHAR_W];
  endfunction

endpackage

### sv/sqa_if.sv
// input channel: a command or a scancode
interface sqa_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [sqa_pkg::SCAN_W-1:0]  scan_byte;

  modport source (output valid, output cmd, output scan_byte, input ready);
  modport sink   (input valid, input cmd, input scan_byte, output ready);
endinterface

// result channel
interface sqa_out_if;
  logic                        valid;
  logic                        ready;
  logic [sqa_pkg::CHAR_W-1:0]  ascii_char;
  logic                        char_valid;
  logic                        key_waiting;
  logic                        char_dropped;

  modport source (output valid, output ascii_char, output char_valid,
                  output key_waiting, output char_dropped, input ready);
  modport sink   (input valid, input ascii_char, input char_valid,
                  input key_waiting, input char_dropped, output ready);
endinterface

### sv/sqa_ram.sv
module sqa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/sqa_front.sv
module sqa_front (
  input  logic           clk,
  input  logic           rst_n,
  sqa_in_if.sink         in_chan,
  output logic           push_valid,
  output sqa_pkg::op_t   push_op,
  input  logic           push_ready
);

  logic             shift_r, shift_nxt;
  logic             caps_r, caps_nxt;
  logic [6:0]       code;
  logic             is_shift;
  logic             accept;
  logic [sqa_pkg::CHAR_W-1:0] ch;
  sqa_pkg::op_t     op;

  assign code     = in_chan.scan_byte[6:0];
  assign is_shift = (code == sqa_pkg::KEY_LSHIFT) || (code == sqa_pkg::KEY_RSHIFT);
  assign accept   = in_chan.valid && push_ready;
  assign ch       = sqa_pkg::key_char(code, shift_r ^ caps_r);

  // classify the item and track modifier state
  always_comb begin
    op.kind   = sqa_pkg::OP_NONE;
    op.ch     = '0;
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    if (in_chan.cmd) begin
      op.kind = sqa_pkg::OP_READ;
    end else if (in_chan.scan_byte[sqa_pkg::REL_BIT_POS]) begin
      if (is_shift) begin
        shift_nxt = 1'b0;
      end
    end else if (is_shift) begin
      shift_nxt = 1'b1;
    end else if (code == sqa_pkg::KEY_CAPS) begin
      caps_nxt = ~caps_r;
    end else if (ch != '0) begin
      op.kind = sqa_pkg::OP_PUSH;
      op.ch   = ch;
    end
  end

  // modifier registers change only on a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      caps_r  <= 1'b0;
    end else if (accept) begin
      shift_r <= shift_nxt;
      caps_r  <= caps_nxt;
    end
  end

  assign in_chan.ready = push_ready;
  assign push_valid    = in_chan.valid;
  assign push_op       = op;

endmodule

### sv/sqa_opq.sv
module sqa_opq #(
  parameter int DEPTH = sqa_pkg::OPQ_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  sqa_pkg::op_t  push_op,
  output logic          push_ready,
  output logic          pop_valid,
  output sqa_pkg::op_t  pop_op,
  input  logic          pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sqa_pkg::op_t   slot_r [DEPTH];
  logic [AW-1:0]  head_r, head_nxt;
  logic [AW-1:0]  tail_r, tail_nxt;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = slot_r[head_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // wrapping pointers
  always_comb begin
    head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[tail_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        tail_r <= tail_nxt;
      end
      if (do_pop) begin
        head_r <= head_nxt;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("op queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("op queue count missed a push");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CW'(1) && do_pop && !do_push) |=> (head_r == tail_r))
    else $error("op queue pointers disagree when empty");
`endif

endmodule

### sv/sqa_back.sv
module sqa_back #(
  parameter int QUEUE_DEPTH = sqa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_valid,
  input  sqa_pkg::op_t  op,
  output logic          op_ready,
  sqa_out_if.source     out_chan
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [AW-1:0] rp_r, rp_nxt, rp_inc;
  logic [AW-1:0] wp_r, wp_nxt, wp_inc;
  logic          out_valid_r;
  logic          char_valid_r, char_valid_nxt;
  logic          key_waiting_r;
  logic          dropped_r, dropped_nxt;
  logic          go;
  logic          empty, full;
  logic          ram_we, ram_re;
  logic [sqa_pkg::CHAR_W-1:0] ram_rdata;

  assign op_ready = !out_valid_r || out_chan.ready;
  assign go       = op_valid && op_ready;

  assign rp_inc = (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + AW'(1);
  assign wp_inc = (wp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + AW'(1);
  assign empty  = (rp_r == wp_r);
  assign full   = (wp_inc == rp_r);

  // carry out one queued op against the character ring
  always_comb begin
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    char_valid_nxt = 1'b0;
    dropped_nxt    = 1'b0;
    if (go) begin
      case (op.kind)
        sqa_pkg::OP_READ: begin
          if (!empty) begin
            ram_re         = 1'b1;
            rp_nxt         = rp_inc;
            char_valid_nxt = 1'b1;
          end
        end
        sqa_pkg::OP_PUSH: begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            ram_we = 1'b1;
            wp_nxt = wp_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  sqa_ram #(
    .WIDTH (sqa_pkg::CHAR_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_char_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (op.ch),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  // pointers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rp_r <= rp_nxt;
      wp_r <= wp_nxt;
      if (op_ready) begin
        out_valid_r <= go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      char_valid_r  <= char_valid_nxt;
      dropped_r     <= dropped_nxt;
      key_waiting_r <= (rp_nxt != wp_nxt);
    end
  end

  // read data stays in the ram output register while the result waits
  assign out_chan.valid        = out_valid_r;
  assign out_chan.ascii_char   = char_valid_r ? ram_rdata : '0;
  assign out_chan.char_valid   = char_valid_r;
  assign out_chan.key_waiting  = key_waiting_r;
  assign out_chan.char_dropped = dropped_r;

`ifndef SYNTHESIS
  a_no_move_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> ($stable(rp_r) && $stable(wp_r)))
    else $error("ring pointers moved while result stalled");
  a_read_data_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready && char_valid_r) |=> $stable(ram_rdata))
    else $error("read data changed under a stalled result");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(char_valid_r && dropped_r))
    else $error("read and drop reported together");
  a_pop_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (go && op.kind == sqa_pkg::OP_READ && !empty) |=> (rp_r != $past(rp_r)))
    else $error("read did not advance the read pointer");
`endif

endmodule

### sv/scancode_set1_ascii_queue_core.sv
// Set 1 scancode to ASCII translator with a character ring. Each input item is
// either a scancode byte (cmd = 0) or a read request (cmd = 1), and each one
// gives exactly one result. Shift presses and releases and caps lock toggles
// update modifier state; other presses are looked up in a US-QWERTY table and
// queued when nonzero, or reported as dropped when the ring holds
// QUEUE_DEPTH-1 characters. The block takes one item per cycle while the
// output is not stalled: the classifier handles an item in the cycle it is
// accepted, a small op queue decouples it from the ring engine, and the ring
// engine performs one read or write on the single-port-per-direction character
// RAM each cycle it is not stalled, which sets that rate. A transferred item
// passes through the op queue and then the result register; ops waiting ahead
// in it delay the result. The character RAM needs no clearing after reset.
module scancode_set1_ascii_queue_core #(
  parameter int QUEUE_DEPTH = sqa_pkg::QUEUE_DEPTH_DEF,
  parameter int OPQ_DEPTH   = sqa_pkg::OPQ_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sqa_in_if.sink     in_chan,
  sqa_out_if.source  out_chan
);

  logic          push_valid, push_ready;
  sqa_pkg::op_t  push_op;
  logic          pop_valid, pop_ready;
  sqa_pkg::op_t  pop_op;

  // classify incoming items
  sqa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready)
  );

  // decoupling queue
  sqa_opq #(
    .DEPTH (OPQ_DEPTH)
  ) u_opq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op),
    .pop_ready  (pop_ready)
  );

  // ring engine and result register
  sqa_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (pop_valid),
    .op       (pop_op),
    .op_ready (pop_ready),
    .out_chan (out_chan)
  );

endmodule
